@@ rtl/uer_pkg.sv @@
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

   // Sequencer phases.
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_PRE  = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_WAIT = 3'd3;
   localparam logic [2:0] PH_MEAS = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_ECHO  = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_UNIT_INCHES   = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd30000;

   // Q16 conversion factors from echo ticks to distance.
   localparam logic [10:0] K_CM_Q16 = 11'd1125;
   localparam logic [10:0] K_IN_Q16 = 11'd443;
   localparam logic [26:0] ROUND_HALF = 27'd32768;

   typedef struct packed {
      logic       start_req;
      logic [7:0] tries;
      logic       echo_level;
   } req_type;

   typedef struct packed {
      logic        trigger_level;
      logic        busy_res;
      logic        done_res;
      logic [10:0] distance;
      logic [1:0]  status;
   } rsp_type;

endpackage

@@ rtl/uer_ctrl.sv @@
// Measurement sequencer: trigger pulse, echo wait, echo width count and retries.
module uer_ctrl #(
   parameter int TRIGGER_HIGH_TICKS    = 10,
   parameter int TRIGGER_PRE_LOW_TICKS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  uer_pkg::req_type req,
   input  logic             unit_inches,
   input  logic [15:0]      timeout_ticks,
   output uer_pkg::rsp_type rsp
);
   import uer_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  tries_ff, tries_in;

   logic [2:0]  cur_phase;
   logic [15:0] cur_count;
   logic [7:0]  cur_tries;
   logic [15:0] count_inc;
   logic        fail;
   logic [1:0]  fail_code;
   logic [10:0] k_sel;
   logic [26:0] product;
   logic [26:0] rounded;
   logic [7:0]  tries_dec;

   // Only the measurement phase uses the product, where the count is the stored one.
   assign k_sel   = unit_inches ? K_IN_Q16 : K_CM_Q16;
   assign product = 27'(count_ff) * 27'(k_sel);
   assign rounded = product + ROUND_HALF;

   always_comb begin
      cur_phase = phase_ff;
      cur_count = count_ff;
      cur_tries = tries_ff;
      if (phase_ff == PH_IDLE && req.start_req) begin
         cur_phase = PH_PRE;
         cur_count = '0;
         cur_tries = (req.tries == 8'd0) ? 8'd1 : req.tries;
      end
      count_inc = cur_count + 16'd1;

      phase_in  = cur_phase;
      count_in  = cur_count;
      tries_in  = cur_tries;
      fail      = 1'b0;
      fail_code = ST_OK;
      rsp       = '0;

      case (cur_phase)
         PH_PRE: begin
            count_in = count_inc;
            if (count_inc >= 16'(TRIGGER_PRE_LOW_TICKS)) begin
               phase_in = PH_HIGH;
               count_in = '0;
            end
         end
         PH_HIGH: begin
            rsp.trigger_level = 1'b1;
            count_in = count_inc;
            if (count_inc >= 16'(TRIGGER_HIGH_TICKS)) begin
               phase_in = PH_WAIT;
               count_in = '0;
            end
         end
         PH_WAIT: begin
            if (req.echo_level) begin
               // The rising tick already counts as the first high tick.
               count_in = 16'd1;
               if (timeout_ticks <= 16'd1) begin
                  fail      = 1'b1;
                  fail_code = ST_TOO_LONG;
               end else begin
                  phase_in = PH_MEAS;
               end
            end else begin
               count_in = count_inc;
               if (count_inc >= timeout_ticks) begin
                  fail      = 1'b1;
                  fail_code = ST_NO_ECHO;
               end
            end
         end
         PH_MEAS: begin
            if (req.echo_level) begin
               count_in = count_inc;
               if (count_inc >= timeout_ticks) begin
                  fail      = 1'b1;
                  fail_code = ST_TOO_LONG;
               end
            end else begin
               rsp.distance = rounded[26:16];
               rsp.done_res = 1'b1;
               rsp.status   = ST_OK;
               phase_in     = PH_IDLE;
               count_in     = '0;
               tries_in     = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      tries_dec = (cur_tries == 8'd0) ? 8'd0 : cur_tries - 8'd1;
      if (fail) begin
         tries_in = tries_dec;
         count_in = '0;
         if (tries_dec == 8'd0) begin
            rsp.done_res = 1'b1;
            rsp.status   = fail_code;
            phase_in     = PH_IDLE;
         end else begin
            phase_in = PH_PRE;
         end
      end

      rsp.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         tries_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         tries_ff <= tries_in;
      end
   end

endmodule

@@ rtl/ultrasonic_echo_ranger_unit.sv @@
// Top level of the ultrasonic echo ranger: handshake, settings and result register.
//
// Each req item is one microsecond tick: the sampled echo level plus an
// optional start request with a try count (zero is taken as one try).
// Every item yields exactly one rsp item carrying the trigger pin level,
// busy and done flags, and on a finished measurement the status and the
// rounded distance in centimeters or inches.
// The step logic runs between the sequencer state and the rsp register, so
// a result appears in the cycle after its item is taken, and one item is
// taken every cycle while rsp_ready stays high.
// The rsp register holds one item; req_ready drops only while it is full and
// rsp_ready is low, so a stalled receiver stalls the sender with no loss.
// The csr port writes the unit select and the timeout at any edge where
// csr_we is high; writes are expected only while no measurement is running.
// Synchronous reset empties the rsp register, returns the sequencer to idle
// and loads centimeters with a timeout of 30000 ticks.
module ultrasonic_echo_ranger_unit #(
   parameter int TRIGGER_HIGH_TICKS    = 10,
   parameter int TRIGGER_PRE_LOW_TICKS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uer_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uer_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);
   import uer_pkg::*;

   logic        unit_inches_ff;
   logic [15:0] timeout_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_in;
   logic        accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   uer_ctrl #(
      .TRIGGER_HIGH_TICKS   (TRIGGER_HIGH_TICKS),
      .TRIGGER_PRE_LOW_TICKS(TRIGGER_PRE_LOW_TICKS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .req          (req_data),
      .unit_inches  (unit_inches_ff),
      .timeout_ticks(timeout_ff),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_inches_ff <= 1'b0;
         timeout_ff     <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNIT_INCHES:   unit_inches_ff <= csr_wdata[0];
            CSR_TIMEOUT_TICKS: timeout_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

@@ rtl/uer_checker.sv @@
// Port-level checks for the ultrasonic echo ranger, bound to its top level.
module uer_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input uer_pkg::rsp_type rsp_data
);
   import uer_pkg::*;

   // A held result must not move while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // Every accepted item produces a result on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // A finishing tick leaves the block idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   // Status and distance are zero unless the measurement finishes.
   a_quiet_unless_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == ST_OK
                                       && rsp_data.distance == 11'd0)
      else $error("status or distance set without done");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (.*);

@@ tb/echo_ranger_checker.sv @@
// Checker for the ultrasonic echo ranger: tracks the sequencer and compares every rsp item.
`timescale 1ns / 100ps

module echo_ranger_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  uer_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  uer_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               pending,
   output logic [2:0]       seq_phase
);
   import uer_pkg::*;

   localparam int          PRE_LOW_TICKS   = 2;
   localparam int          TRIG_HIGH_TICKS = 10;
   localparam logic [31:0] CM_Q16          = 32'd1125;
   localparam logic [31:0] INCH_Q16        = 32'd443;
   localparam logic [31:0] HALF_Q16        = 32'd32768;

   logic        in_inches;
   logic [15:0] echo_limit;
   logic [2:0]  phase;
   logic [15:0] ticks;
   logic [7:0]  tries_left;
   rsp_type     outputs_due[$];
   int          mismatches = 0;

   // One microsecond tick of the sequencer: updates the tracked state and
   // returns the rsp item the block owes for this req item.
   task advance_ranger(input req_type item, output rsp_type r);
      logic        failed;
      logic [1:0]  fail_code;
      logic [31:0] scaled;
      failed = 1'b0;
      fail_code = ST_OK;
      r = '0;
      if (phase == PH_IDLE && item.start_req) begin
         tries_left = (item.tries != 8'd0) ? item.tries : 8'd1;
         phase = PH_PRE;
         ticks = '0;
      end
      case (phase)
         PH_IDLE: ;
         PH_PRE: begin
            ticks = ticks + 16'd1;
            if (ticks >= 16'(PRE_LOW_TICKS)) begin
               phase = PH_HIGH;
               ticks = '0;
            end
         end
         PH_HIGH: begin
            r.trigger_level = 1'b1;
            ticks = ticks + 16'd1;
            if (ticks >= 16'(TRIG_HIGH_TICKS)) begin
               phase = PH_WAIT;
               ticks = '0;
            end
         end
         PH_WAIT: begin
            if (item.echo_level) begin
               // The rising tick already counts as the first tick of the pulse.
               ticks = 16'd1;
               if (ticks >= echo_limit) begin
                  failed = 1'b1;
                  fail_code = ST_TOO_LONG;
               end else begin
                  phase = PH_MEAS;
               end
            end else begin
               ticks = ticks + 16'd1;
               if (ticks >= echo_limit) begin
                  failed = 1'b1;
                  fail_code = ST_NO_ECHO;
               end
            end
         end
         PH_MEAS: begin
            if (item.echo_level) begin
               ticks = ticks + 16'd1;
               if (ticks >= echo_limit) begin
                  failed = 1'b1;
                  fail_code = ST_TOO_LONG;
               end
            end else begin
               scaled = {16'd0, ticks} * (in_inches ? INCH_Q16 : CM_Q16) + HALF_Q16;
               r.distance = scaled[26:16];
               r.done_res = 1'b1;
               r.status = ST_OK;
               phase = PH_IDLE;
               ticks = '0;
               tries_left = '0;
            end
         end
         default: phase = PH_IDLE;
      endcase
      if (failed) begin
         if (tries_left != 8'd0) tries_left = tries_left - 8'd1;
         ticks = '0;
         if (tries_left == 8'd0) begin
            r.done_res = 1'b1;
            r.status = fail_code;
            phase = PH_IDLE;
         end else begin
            phase = PH_PRE;
         end
      end
      r.busy_res = (phase != PH_IDLE);
   endtask

   task report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   task compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) report($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   task check_rsp(input rsp_type got);
      rsp_type want;
      if (outputs_due.size() == 0) begin
         report($sformatf("rsp item %h arrived with none outstanding", got));
      end else begin
         want = outputs_due.pop_front();
         compare_field("trigger_level", 16'(want.trigger_level), 16'(got.trigger_level));
         compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
         compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
         compare_field("distance", 16'(want.distance), 16'(got.distance));
         compare_field("status", 16'(want.status), 16'(got.status));
      end
   endtask

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         in_inches = 1'b0;
         echo_limit = TIMEOUT_RESET;
         phase = PH_IDLE;
         ticks = '0;
         tries_left = '0;
         outputs_due.delete();
      end else begin
         // A result leaving now is older than an item entering now.
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
         if (req_valid && req_ready) begin
            advance_ranger(req_data, due);
            outputs_due.push_back(due);
         end
         if (csr_we) begin
            if (csr_index == CSR_UNIT_INCHES) in_inches = csr_wdata[0];
            else echo_limit = csr_wdata;
         end
      end
      fail_count <= mismatches;
      pending <= outputs_due.size();
      seq_phase <= phase;
   end

endmodule

@@ tb/tb_ultrasonic_echo_ranger_unit.sv @@
// Testbench top of the ultrasonic echo ranger: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger_unit;
   import uer_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_UNIT_INCHES;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   logic [2:0]  seq_phase;

   // Echo shaping for the attempt in progress.
   logic        calm = 1'b0;
   logic        plan_random = 1'b0;
   logic        plan_noise = 1'b0;
   int          wait_len = 0;
   int          high_len = 1;
   int          wait_seen = 0;
   int          high_seen = 0;
   logic        saw_idle = 1'b1;
   logic [15:0] limit_now = TIMEOUT_RESET;
   int          ticks_sent = 0;

   always #10 clock = ~clock;

   ultrasonic_echo_ranger_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   echo_ranger_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .seq_phase  (seq_phase)
   );

   initial begin
      #200_000_000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random stall bursts, with stretches of steady readiness.
   initial begin
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_ready = 1'b1;
         end else if ($urandom_range(0, 99) == 0) begin
            repeat (150) @(negedge clock);
         end
      end
   end

   // Sends one tick. The echo level follows the tracked sequencer phase so that
   // the planned wait and pulse land in the right phases.
   task automatic push_tick(input logic want_start, input logic [7:0] n_tries);
      req_type item;
      int      pick;
      int      span;
      @(negedge clock);
      item.start_req = 1'($urandom_range(0, 1));
      item.tries = 8'($urandom_range(0, 255));
      item.echo_level = 1'($urandom_range(0, 1));
      saw_idle = (seq_phase == PH_IDLE);
      case (seq_phase)
         PH_IDLE: begin
            item.start_req = want_start;
            if (want_start) item.tries = n_tries;
         end
         PH_PRE: begin
            wait_seen = 0;
            high_seen = 0;
            if (plan_random) begin
               pick = $urandom_range(0, 19);
               span = (limit_now > 16'd61) ? 60 : int'(limit_now) - 1;
               plan_noise = (pick < 4);
               if (pick < 7) begin
                  wait_len = 1 << 20;
                  high_len = 1;
               end else if (pick < 10 || span < 1) begin
                  wait_len = $urandom_range(0, 5);
                  high_len = 1 << 20;
               end else begin
                  wait_len = ($urandom_range(0, 3) == 0) ? span : $urandom_range(0, span);
                  high_len = ($urandom_range(0, 3) == 0) ? int'(limit_now) - 1
                                                         : $urandom_range(1, span);
               end
            end
         end
         PH_WAIT: begin
            if (!plan_noise) begin
               if (wait_seen < wait_len) begin
                  item.echo_level = 1'b0;
                  wait_seen++;
               end else begin
                  item.echo_level = 1'b1;
                  high_seen = 1;
               end
            end
         end
         PH_MEAS: begin
            if (!plan_noise) begin
               item.echo_level = (high_seen < high_len);
               if (item.echo_level) high_seen++;
            end
         end
         default: ;
      endcase
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      if (!calm && $urandom_range(0, 15) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // One full measurement; returns after the first idle tick that follows it.
   task automatic measure(input logic [7:0] n_tries);
      push_tick(1'b1, n_tries);
      do push_tick(1'b0, 8'd0); while (!saw_idle);
   endtask

   task automatic fix_echo(input int wait_ticks, input int high_ticks);
      plan_random = 1'b0;
      plan_noise = 1'b0;
      wait_len = wait_ticks;
      high_len = high_ticks;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      drain_results();
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == CSR_TIMEOUT_TICKS) limit_now = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      int sweep;
      int k;
      logic [15:0] limit_pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: centimeters, long timeout; zero tries means one.
      fix_echo(3, 7);
      measure(8'd0);
      measure(8'd255);

      // With a one-tick timeout an immediate echo is already too long and
      // silence fails on its first tick; every try is used up.
      write_csr(CSR_TIMEOUT_TICKS, 16'd1);
      fix_echo(0, 5);
      measure(8'd3);
      fix_echo(100, 1);
      measure(8'd6);
      write_csr(CSR_TIMEOUT_TICKS, 16'd0);
      fix_echo(100, 1);
      measure(8'd2);
      fix_echo(0, 1);
      measure(8'd1);

      // Pulses at the timeout: the longest one that still passes, then one too long.
      write_csr(CSR_TIMEOUT_TICKS, 16'd80);
      fix_echo(0, 79);
      measure(8'd1);
      write_csr(CSR_UNIT_INCHES, 16'hFFFF);
      fix_echo(2, 80);
      measure(8'd1);

      // Medium pulses in both units exercise the scaling and rounding.
      for (sweep = 0; sweep < 6; sweep++) begin
         if (sweep % 3 == 0)
            write_csr(CSR_UNIT_INCHES, {15'($urandom), 1'((sweep / 3) % 2)});
         fix_echo($urandom_range(0, 20), $urandom_range(1, 40));
         measure(8'($urandom_range(0, 2)));
      end

      plan_random = 1'b1;
      while (ticks_sent < 1450) begin
         write_csr(CSR_UNIT_INCHES, 16'($urandom));
         case ($urandom_range(0, 7))
            0: limit_pick = 16'd1;
            1: limit_pick = 16'd2;
            2: limit_pick = 16'($urandom_range(3, 300));
            default: limit_pick = 16'($urandom_range(3, 40));
         endcase
         write_csr(CSR_TIMEOUT_TICKS, limit_pick);
         repeat ($urandom_range(3, 8)) begin
            if (ticks_sent > 1250) calm = 1'b1;
            if ($urandom_range(0, 9) == 0) drain_results();
            k = $urandom_range(0, 3);
            repeat (k) push_tick(1'b0, 8'd0);
            case ($urandom_range(0, 19))
               0: measure(8'd0);
               1: measure(8'($urandom_range(5, 8)));
               default: measure(8'($urandom_range(1, 3)));
            endcase
         end
      end

      calm = 1'b1;
      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/uer_pkg.sv
rtl/uer_ctrl.sv
rtl/ultrasonic_echo_ranger_unit.sv
rtl/uer_checker.sv
tb/echo_ranger_checker.sv
tb/tb_ultrasonic_echo_ranger_unit.sv
